[rtl/gf2rta_pkg.sv]
package gf2rta_pkg;

    // Item kinds on the input channel; the fourth code is ignored.
    typedef enum logic [1:0] {
        KIND_ADD   = 2'd0,
        KIND_READ  = 2'd1,
        KIND_CLEAR = 2'd2
    } kind_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture the accepted word and set up the row address
        logic step;      // advance the row sweep by one row
        logic clr_wr;    // write zero to the current row
        logic rmw;       // read the current row for a read-modify-write
        logic out_load;  // load the output register from the read data, or zero for an out-of-range read
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last;      // the sweep is at the final row
    } status_t;

endpackage

[rtl/gf2rta_dpath.sv]
module gf2rta_dpath #(
    parameter  int SIZE  = 25,
    localparam int IDX_W = $clog2(SIZE)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  gf2rta_pkg::cmd_t      cmd,
    output gf2rta_pkg::status_t   status,
    input  logic [1:0]            s_kind,
    input  logic [SIZE-1:0]       s_term_u,
    input  logic [SIZE-1:0]       s_term_v,
    input  logic [SIZE-1:0]       s_term_w,
    input  logic [IDX_W-1:0]      s_row_first,
    input  logic [IDX_W-1:0]      s_row_second,
    output logic [SIZE-1:0]       m_row_bits
);

    localparam int DEPTH  = SIZE * SIZE;
    localparam int ADDR_W = $clog2(DEPTH);

    logic [SIZE-1:0]   mem [DEPTH];

    logic [SIZE-1:0]   u_reg, v_reg, w_reg;
    logic              oor_reg, oor_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [IDX_W-1:0]  i_reg, i_next;
    logic [IDX_W-1:0]  j_reg, j_next;
    logic [SIZE-1:0]   rd_data_reg;
    logic [ADDR_W-1:0] pend_addr_reg;
    logic              pend_sel_reg;
    logic              pend_valid_reg;
    logic [SIZE-1:0]   out_reg;

    logic [ADDR_W-1:0] read_addr;
    logic              last_row;
    logic              last_j;

    assign read_addr = ADDR_W'(s_row_first) * ADDR_W'(SIZE) + ADDR_W'(s_row_second);
    assign oor_next  = (32'(s_row_first) >= SIZE) || (32'(s_row_second) >= SIZE);
    assign last_row  = (addr_reg == ADDR_W'(DEPTH - 1));
    assign last_j    = (j_reg == IDX_W'(SIZE - 1));
    assign status.last = last_row;

    always_comb begin
        addr_next = addr_reg;
        i_next    = i_reg;
        j_next    = j_reg;
        priority if (cmd.load) begin
            i_next = '0;
            j_next = '0;
            if ((s_kind == gf2rta_pkg::KIND_READ) && !oor_next) begin
                addr_next = read_addr;
            end else begin
                addr_next = '0;
            end
        end else if (cmd.step) begin
            if (last_row) begin
                addr_next = '0;
            end else begin
                addr_next = addr_reg + ADDR_W'(1);
            end
            if (last_j) begin
                j_next = '0;
                i_next = (i_reg == IDX_W'(SIZE - 1)) ? '0 : i_reg + IDX_W'(1);
            end else begin
                j_next = j_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg       <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            pend_valid_reg <= 1'b0;
        end else begin
            addr_reg       <= addr_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            pend_valid_reg <= cmd.rmw;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            u_reg   <= s_term_u;
            v_reg   <= s_term_v;
            w_reg   <= s_term_w;
            oor_reg <= oor_next;
        end
        pend_addr_reg <= addr_reg;
        pend_sel_reg  <= u_reg[i_reg] & v_reg[j_reg];
        if (cmd.out_load) begin
            out_reg <= oor_reg ? '0 : rd_data_reg;
        end
    end

    // One read and one write a cycle. During an add the row read in one cycle is written
    // back in the next if its u and v bits are both set, while the following row is being read.
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[addr_reg];
        if (cmd.clr_wr) begin
            mem[addr_reg] <= '0;
        end else if (pend_valid_reg && pend_sel_reg) begin
            mem[pend_addr_reg] <= rd_data_reg ^ w_reg;
        end
    end

    assign m_row_bits = out_reg;

    a_no_rmw_during_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.clr_wr && pend_valid_reg))
        else $error("write-back pending while clearing");

    a_rmw_sequential: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_valid_reg && cmd.rmw) |-> (addr_reg == pend_addr_reg + ADDR_W'(1)))
        else $error("read-modify-write rows out of order");

    a_addr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        addr_reg <= ADDR_W'(DEPTH - 1))
        else $error("row address beyond store");

endmodule

[rtl/gf2rta_ctrl.sv]
module gf2rta_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_kind,
    output logic                  m_valid,
    input  logic                  m_ready,
    output gf2rta_pkg::cmd_t      cmd,
    input  gf2rta_pkg::status_t   status
);

    typedef enum logic [6:0] {
        ST_INIT    = 7'b0000001,
        ST_IDLE    = 7'b0000010,
        ST_ADD     = 7'b0000100,
        ST_DRAIN   = 7'b0001000,
        ST_CLEAR   = 7'b0010000,
        ST_RD_ADDR = 7'b0100000,
        ST_RD_DATA = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    assign cmd.load     = accept;
    assign cmd.step     = (state_reg == ST_INIT) || (state_reg == ST_CLEAR) ||
                          (state_reg == ST_ADD);
    assign cmd.clr_wr   = (state_reg == ST_INIT) || (state_reg == ST_CLEAR);
    assign cmd.rmw      = (state_reg == ST_ADD);
    assign cmd.out_load = (state_reg == ST_RD_DATA) && (!out_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT: begin
                if (status.last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (accept) begin
                    unique case (s_kind)
                        gf2rta_pkg::KIND_ADD:   state_next = ST_ADD;
                        gf2rta_pkg::KIND_READ:  state_next = ST_RD_ADDR;
                        gf2rta_pkg::KIND_CLEAR: state_next = ST_CLEAR;
                        default:                state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ADD: begin
                if (status.last) state_next = ST_DRAIN;
            end
            ST_DRAIN:   state_next = ST_IDLE;
            ST_CLEAR: begin
                if (status.last) state_next = ST_IDLE;
            end
            ST_RD_ADDR: state_next = ST_RD_DATA;
            ST_RD_DATA: begin
                if (cmd.out_load) state_next = ST_IDLE;
            end
            default:    state_next = ST_INIT;
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_INIT;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid = out_valid_reg;

    a_add_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ADD && status.last) |=> (state_reg == ST_DRAIN))
        else $error("add sweep ended without write-back cycle");

    a_rd_data_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(state_reg == ST_RD_DATA) |-> ($past(state_reg) == ST_RD_ADDR))
        else $error("read data state entered without address cycle");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |-> !cmd.out_load)
        else $error("output register overwritten before it was taken");

endmodule

[rtl/gf2_rank_one_tensor_accumulate_top.sv]
// Channel  Handshake          Payload
// s_       s_valid/s_ready    s_kind, s_term_u, s_term_v, s_term_w, s_row_first, s_row_second
// m_       m_valid/m_ready    m_row_bits
//
// The store holds SIZE*SIZE rows (625 at SIDE = 5) in one memory with one read and one
// write port, so every sweep handles one row per cycle.
// Add: a read-modify-write sweep over every row, then a drain for the last write-back.
// Clear: zeroing sweep. Read: address and data steps, plus any output register wait.
// After reset the store is zeroed by a clearing pass over every row, with s_ready low.
// A read result waits in the output register; a stall there holds only a following read.
module gf2_rank_one_tensor_accumulate_top #(
    parameter  int SIDE  = 5,
    localparam int SIZE  = SIDE * SIDE,
    localparam int IDX_W = $clog2(SIZE)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_kind,
    input  logic [SIZE-1:0]   s_term_u,
    input  logic [SIZE-1:0]   s_term_v,
    input  logic [SIZE-1:0]   s_term_w,
    input  logic [IDX_W-1:0]  s_row_first,
    input  logic [IDX_W-1:0]  s_row_second,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [SIZE-1:0]   m_row_bits
);

    gf2rta_pkg::cmd_t    cmd;
    gf2rta_pkg::status_t status;

    gf2rta_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_kind  (s_kind),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    gf2rta_dpath #(
        .SIZE (SIZE)
    ) u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .s_kind       (s_kind),
        .s_term_u     (s_term_u),
        .s_term_v     (s_term_v),
        .s_term_w     (s_term_w),
        .s_row_first  (s_row_first),
        .s_row_second (s_row_second),
        .m_row_bits   (m_row_bits)
    );

endmodule
